// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/lgspm_pkg.sv =====
// Types, constants and helpers of the letter graph meeting-point block.
package lgspm_pkg;

   localparam int NODES    = 26;
   localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int ADDR_W   = $clog2(NODES * NODES);
   localparam int SYM_W    = 5;
   localparam int WGT_W    = 10;
   localparam int DIST_W   = 17;
   localparam int COST_W   = 16;
   localparam int TOTAL_W  = 32;

   localparam logic [DIST_W-1:0]  UNREACH   = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX  = {1'b0, {COST_W{1'b1}}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DIST_W-1:0] dist_type;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_EDGE  = 2'd1,
      MODE_CLOSE = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef struct packed {
      logic     load;
      logic     clr_stats;
      logic     q_init;
      logic     clr_wr;
      logic     edge_rd;
      logic     edge_wr;
      logic     ik_rd;
      logic     ik_cap;
      logic     row_rd;
      logic     q_rd;
      logic     q_fin;
      node_type k;
      node_type i;
      node_type j;
   } cmd_type;

   typedef struct packed {
      logic ik_unreach;
      logic out_busy;
   } status_type;

   function automatic addr_type addr_of(node_type r, node_type c);
      return ADDR_W'(r) * ADDR_W'(NODES) + ADDR_W'(c);
   endfunction

endpackage

// ===== design/lgspm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module lgspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/lgspm_ctrl.sv =====
// Controller: sequences clear sweeps, edge updates, closure and queries.
module lgspm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  lgspm_pkg::status_type status,
   output lgspm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_EDGE_RD, S_EDGE_WR, S_IK_RD, S_IK_CAP,
      S_ROW, S_ROW_END, S_Q_RD, S_Q_END, S_Q_FIN
   } state_type;

   localparam lgspm_pkg::node_type LAST = lgspm_pkg::NODE_W'(lgspm_pkg::NODES - 1);

   state_type           state_ff;
   lgspm_pkg::node_type k_ff, i_ff, j_ff;
   lgspm_pkg::mode_type mode;

   assign mode      = lgspm_pkg::mode_type'(req_mode);
   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_CLR: begin
               if (j_ff == LAST) begin
                  j_ff <= '0;
                  if (i_ff == LAST) begin
                     i_ff     <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  k_ff <= '0;
                  i_ff <= '0;
                  j_ff <= '0;
                  unique case (mode)
                     lgspm_pkg::MODE_CLEAR: state_ff <= S_CLR;
                     lgspm_pkg::MODE_EDGE:  state_ff <= S_EDGE_RD;
                     lgspm_pkg::MODE_CLOSE: state_ff <= S_IK_RD;
                     lgspm_pkg::MODE_QUERY: state_ff <= S_Q_RD;
                     default:               state_ff <= S_IDLE;
                  endcase
               end
            end
            S_EDGE_RD: state_ff <= S_EDGE_WR;
            S_EDGE_WR: state_ff <= S_IDLE;
            S_IK_RD:   state_ff <= S_IK_CAP;
            S_IK_CAP: begin
               j_ff     <= '0;
               state_ff <= status.ik_unreach ? S_ROW_END : S_ROW;
            end
            S_ROW: begin
               if (j_ff == LAST) begin
                  state_ff <= S_ROW_END;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_ROW_END: begin
               if (i_ff == LAST) begin
                  i_ff <= '0;
                  if (k_ff == LAST) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_IK_RD;
                  end
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_IK_RD;
               end
            end
            S_Q_RD: begin
               if (j_ff == LAST) begin
                  state_ff <= S_Q_END;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_Q_END: state_ff <= S_Q_FIN;
            S_Q_FIN: begin
               if (!status.out_busy) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_CLR;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.k         = k_ff;
      cmd.i         = i_ff;
      cmd.j         = j_ff;
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.clr_stats = cmd.load && (mode == lgspm_pkg::MODE_CLEAR);
      cmd.q_init    = cmd.load && (mode == lgspm_pkg::MODE_QUERY);
      cmd.clr_wr    = (state_ff == S_CLR);
      cmd.edge_rd   = (state_ff == S_EDGE_RD);
      cmd.edge_wr   = (state_ff == S_EDGE_WR);
      cmd.ik_rd     = (state_ff == S_IK_RD);
      cmd.ik_cap    = (state_ff == S_IK_CAP);
      cmd.row_rd    = (state_ff == S_ROW);
      cmd.q_rd      = (state_ff == S_Q_RD);
      cmd.q_fin     = (state_ff == S_Q_FIN) && !status.out_busy;
   end

endmodule

// ===== design/lgspm_dp.sv =====
// Datapath: distance memory, relaxation, query search and result register.
module lgspm_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lgspm_pkg::cmd_type                  cmd,
   input  logic [lgspm_pkg::SYM_W-1:0]         req_from_symbol,
   input  logic [lgspm_pkg::SYM_W-1:0]         req_to_symbol,
   input  logic [lgspm_pkg::WGT_W-1:0]         req_weight,
   output lgspm_pkg::status_type               status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [lgspm_pkg::SYM_W-1:0]         rsp_meet_symbol,
   output logic [lgspm_pkg::COST_W-1:0]        rsp_pair_cost,
   output logic                                rsp_reachable,
   output logic [lgspm_pkg::TOTAL_W-1:0]       rsp_total_cost,
   output logic                                rsp_any_failed
);

   localparam int DIST_W  = lgspm_pkg::DIST_W;
   localparam int TOTAL_W = lgspm_pkg::TOTAL_W;

   logic [lgspm_pkg::SYM_W-1:0] a_ff, b_ff;
   logic [lgspm_pkg::WGT_W-1:0] w_ff;
   lgspm_pkg::dist_type         ik_ff, best_ff;
   lgspm_pkg::addr_type         wr_addr_ff;
   logic                        wr_pend_ff, q_ev_ff, found_ff;
   lgspm_pkg::node_type         m_ff, best_m_ff;
   logic [TOTAL_W-1:0]          total_ff;
   logic                        fail_ff;
   logic                        rsp_valid_ff;
   logic [lgspm_pkg::SYM_W-1:0] meet_ff;
   logic [lgspm_pkg::COST_W-1:0] pair_ff;
   logic                        reach_ff;
   logic [TOTAL_W-1:0]          total_out_ff;
   logic                        failed_ff;

   lgspm_pkg::node_type  a_node, b_node;
   logic                 a_ok, b_ok;
   lgspm_pkg::addr_type  rd_addr_a, rd_addr_b, wr_addr;
   lgspm_pkg::dist_type  rd_data_a, rd_data_b, wr_data, relax;
   logic                 wr_en;
   logic [DIST_W:0]      relax_sum;
   lgspm_pkg::dist_type  q_sum;
   logic                 q_take;
   logic [lgspm_pkg::COST_W-1:0] cost;
   logic [TOTAL_W:0]     total_sum;
   logic [TOTAL_W-1:0]   total_new;

   assign a_node = lgspm_pkg::NODE_W'(a_ff);
   assign b_node = lgspm_pkg::NODE_W'(b_ff);
   assign a_ok   = (32'(a_ff) < lgspm_pkg::NODES);
   assign b_ok   = (32'(b_ff) < lgspm_pkg::NODES);

   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      if (cmd.edge_rd && a_ok && b_ok) begin
         rd_addr_a = lgspm_pkg::addr_of(a_node, b_node);
      end else if (cmd.ik_rd) begin
         rd_addr_a = lgspm_pkg::addr_of(cmd.i, cmd.k);
      end else if (cmd.row_rd) begin
         rd_addr_a = lgspm_pkg::addr_of(cmd.k, cmd.j);
         rd_addr_b = lgspm_pkg::addr_of(cmd.i, cmd.j);
      end else if (cmd.q_rd && a_ok && b_ok) begin
         rd_addr_a = lgspm_pkg::addr_of(a_node, cmd.j);
         rd_addr_b = lgspm_pkg::addr_of(b_node, cmd.j);
      end
   end

   assign relax_sum = {1'b0, ik_ff} + {1'b0, rd_data_a};
   assign relax     = (relax_sum > (DIST_W+1)'(lgspm_pkg::DIST_MAX)) ?
                      lgspm_pkg::DIST_MAX : relax_sum[DIST_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      priority if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = lgspm_pkg::addr_of(cmd.i, cmd.j);
         wr_data = (cmd.i == cmd.j) ? '0 : lgspm_pkg::UNREACH;
      end else if (cmd.edge_wr) begin
         wr_en   = a_ok && b_ok && (DIST_W'(w_ff) < rd_data_a);
         wr_addr = lgspm_pkg::addr_of(a_node, b_node);
         wr_data = DIST_W'(w_ff);
      end else if (wr_pend_ff) begin
         wr_en   = (rd_data_a != lgspm_pkg::UNREACH) && (relax < rd_data_b);
         wr_addr = wr_addr_ff;
         wr_data = relax;
      end
   end

   lgspm_ram #(
      .WIDTH (DIST_W),
      .DEPTH (lgspm_pkg::NODES * lgspm_pkg::NODES)
   ) u_dist_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign q_sum  = rd_data_a + rd_data_b;
   assign q_take = q_ev_ff && a_ok && b_ok && (rd_data_a != lgspm_pkg::UNREACH) &&
                   (rd_data_b != lgspm_pkg::UNREACH) && (!found_ff || q_sum < best_ff);

   assign cost      = !found_ff ? '0 :
                      (best_ff > lgspm_pkg::DIST_MAX) ? {lgspm_pkg::COST_W{1'b1}} :
                      best_ff[lgspm_pkg::COST_W-1:0];
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(cost);
   assign total_new = total_sum[TOTAL_W] ? lgspm_pkg::TOTAL_MAX : total_sum[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_from_symbol;
         b_ff <= req_to_symbol;
         w_ff <= req_weight;
      end
      if (cmd.ik_cap) begin
         ik_ff <= rd_data_a;
      end
      wr_addr_ff <= lgspm_pkg::addr_of(cmd.i, cmd.j);
      m_ff       <= cmd.j;
      if (q_take) begin
         best_ff   <= q_sum;
         best_m_ff <= m_ff;
      end
      if (cmd.q_fin) begin
         meet_ff      <= found_ff ? lgspm_pkg::SYM_W'(best_m_ff) : '0;
         pair_ff      <= cost;
         reach_ff     <= found_ff;
         total_out_ff <= found_ff ? total_new : total_ff;
         failed_ff    <= fail_ff | !found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff   <= 1'b0;
         q_ev_ff      <= 1'b0;
         found_ff     <= 1'b0;
         total_ff     <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.row_rd;
         q_ev_ff    <= cmd.q_rd;
         if (cmd.q_init) begin
            found_ff <= 1'b0;
         end else if (q_take) begin
            found_ff <= 1'b1;
         end
         if (cmd.clr_stats) begin
            total_ff <= '0;
            fail_ff  <= 1'b0;
         end else if (cmd.q_fin) begin
            if (found_ff) begin
               total_ff <= total_new;
            end else begin
               fail_ff <= 1'b1;
            end
         end
         if (cmd.q_fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_meet_symbol   = meet_ff;
   assign rsp_pair_cost     = pair_ff;
   assign rsp_reachable     = reach_ff;
   assign rsp_total_cost    = total_out_ff;
   assign rsp_any_failed    = failed_ff;
   assign status.ik_unreach = (rd_data_a == lgspm_pkg::UNREACH);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

// ===== design/letter_graph_shortest_path_meet_top.sv =====
// Top level of the letter graph meeting-point block.
// Input words (req_*) carry a mode and two symbols plus a weight. Mode clear
// resets the distance matrix, running total and failure flag; add edge keeps
// the smaller weight per edge; close runs an all-pairs relaxation; query finds
// the cheapest common target of two symbols. Only queries return a word on
// the rsp_* channel, with the meeting symbol, its cost, the running total
// and the sticky failure flag.
// One word is worked at a time; req_ready is high only while idle.
// Add edge does a read-compare-write on the matrix RAM. A query does one
// matrix column pair read per symbol over the two RAM read ports, then
// passes a drain state and a result state, which waits while the output
// register is still full; the result word is registered as the result state
// is left. Close does one inner relaxation per cycle; each row first reads and
// captures its pivot entry, and rows whose pivot entry is unreachable skip the
// relaxation. Clear and reset sweep the matrix, one entry per cycle, with
// req_ready low.
// A result waits in the output register while rsp_ready is low; non-query
// words are still taken, a second query holds until the register frees.
module letter_graph_shortest_path_meet_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [lgspm_pkg::SYM_W-1:0]         req_from_symbol,
   input  logic [lgspm_pkg::SYM_W-1:0]         req_to_symbol,
   input  logic [lgspm_pkg::WGT_W-1:0]         req_weight,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lgspm_pkg::SYM_W-1:0]         rsp_meet_symbol,
   output logic [lgspm_pkg::COST_W-1:0]        rsp_pair_cost,
   output logic                                rsp_reachable,
   output logic [lgspm_pkg::TOTAL_W-1:0]       rsp_total_cost,
   output logic                                rsp_any_failed
);

   lgspm_pkg::cmd_type    cmd;
   lgspm_pkg::status_type status;

   lgspm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   lgspm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_from_symbol (req_from_symbol),
      .req_to_symbol   (req_to_symbol),
      .req_weight      (req_weight),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_meet_symbol (rsp_meet_symbol),
      .rsp_pair_cost   (rsp_pair_cost),
      .rsp_reachable   (rsp_reachable),
      .rsp_total_cost  (rsp_total_cost),
      .rsp_any_failed  (rsp_any_failed)
   );

endmodule

// ===== design/lgspm_checker.sv =====
// Port-level checker for the letter graph meeting-point block, with its bind.
`include "assert_macros.svh"

module lgspm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_meet_symbol,
   input logic [15:0] rsp_pair_cost,
   input logic        rsp_reachable,
   input logic [31:0] rsp_total_cost,
   input logic        rsp_any_failed
);

   logic rsp_stall, rsp_miss, rsp_hit, miss_clean, total_ok;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_miss   = rsp_valid && !rsp_reachable;
   assign rsp_hit    = rsp_valid && rsp_reachable;
   assign miss_clean = (rsp_meet_symbol == 5'd0) && (rsp_pair_cost == 16'd0) && rsp_any_failed;
   assign total_ok   = (rsp_total_cost >= 32'(rsp_pair_cost));

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_total_cost))
   `ASSERT_NEXT(a_rsp_hold_sym, clock, reset, rsp_stall, $stable(rsp_meet_symbol))
   `ASSERT_IMPLY(a_unreach_zero, clock, reset, rsp_miss, miss_clean)
   `ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, !req_ready && !rsp_valid)
   `ASSERT_IMPLY(a_total_covers, clock, reset, rsp_hit, total_ok)

endmodule

bind letter_graph_shortest_path_meet_top lgspm_checker u_lgspm_checker (.*);
